FILE: rtl/fbe_pkg.sv
// ----------------------------------------------------------------------------
// fbe_pkg: shared types and constants for the fenced block extractor
// Character codes, phase and result codes, the result record and the queue
// geometry used by the extractor.
// ----------------------------------------------------------------------------
package fbe_pkg;

  localparam int MAX_LANG = 64;
  localparam int LANG_W   = $clog2(MAX_LANG + 1);

  localparam int BODY_W          = 17;
  localparam logic [BODY_W-1:0] BODY_SAT = {BODY_W{1'b1}};

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS = 1'b1;

  localparam logic [15:0] MAX_BODY_RST   = 16'd16384;
  localparam logic [7:0]  MAX_BLOCKS_RST = 8'd16;

  localparam logic [7:0] CH_TICK = 8'h60;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;

  typedef enum logic [2:0] {
    PH_OUT  = 3'b001,
    PH_LANG = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    KIND_LANG    = 2'd0,
    KIND_BODY    = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNCLOSED  = 3'd4
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [15:0] offset;
    logic [7:0]  blk_num;
    status_t     status;
    logic [15:0] body_length;
    logic [6:0]  lang_length;
    logic [15:0] too_large_total;
    logic [15:0] overflow_total;
    logic        last_result;
  } res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic [15:0] sat16(input logic [BODY_W-1:0] v);
    return v[BODY_W-1] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [6:0] lang_out(input logic [LANG_W-1:0] v);
    return (32'(v) > 32'd127) ? 7'd127 : 7'(v);
  endfunction

endpackage

FILE: rtl/fenced_block_extractor.sv
// ----------------------------------------------------------------------------
// fenced_block_extractor: fenced code block extractor, one text byte per beat
// Streams language and body bytes of backtick-fenced blocks and one verdict
// per closed or abandoned block.
// ----------------------------------------------------------------------------
// Each accepted byte updates the scanner state in the same cycle and pushes
// zero, one or two results into a four-entry result queue; the results are
// registered in the queue before they reach the output. A byte is taken
// in any cycle in which the queue has at least two free entries, so the block runs at
// one byte per cycle as long as the consumer keeps up; a byte that yields two
// results (a language or body byte plus a verdict) adds a second result to the
// output, which the queue absorbs. Consumers cut the byte streams at the
// body_length and lang_length carried by each verdict.
module fenced_block_extractor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte,
  input  logic                             in_end_of_text,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_byte,
  output logic [15:0]                      out_offset,
  output logic [7:0]                       out_blk_num,
  output logic [2:0]                       out_status,
  output logic [15:0]                      out_body_length,
  output logic [6:0]                       out_lang_length,
  output logic [15:0]                      out_too_large_total,
  output logic [15:0]                      out_overflow_total,
  output logic                             out_last_result,
  input  logic                             cfg_we,
  input  logic [fbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [15:0] max_body_r;
  logic [7:0]  max_blocks_r;

  fbe_pkg::phase_t                  phase_r, phase_nxt;
  logic                             als_r, als_nxt;
  logic [1:0]                       tick_r, tick_nxt;
  logic [fbe_pkg::BODY_W-1:0]       body_cnt_r, body_cnt_nxt;
  logic [fbe_pkg::BODY_W-1:0]       flb_r, flb_nxt;
  logic                             bht_r, bht_nxt;
  logic                             lht_r, lht_nxt;
  logic [fbe_pkg::LANG_W-1:0]       lang_cnt_r, lang_cnt_nxt;
  logic [fbe_pkg::LANG_W-1:0]       lte_r, lte_nxt;
  logic [7:0]                       acc_cnt_r, acc_cnt_nxt;
  logic [15:0]                      tl_cnt_r, tl_cnt_nxt;
  logic [15:0]                      of_cnt_r, of_cnt_nxt;

  fbe_pkg::res_t                    q_r [fbe_pkg::Q_DEPTH];
  logic [fbe_pkg::Q_AW-1:0]         wr_ptr_r, rd_ptr_r, wr_ptr_p1;
  logic [fbe_pkg::Q_CW-1:0]         cnt_r, cnt_nxt;

  logic                             in_acc, pop, closed;
  logic                             e_byte, e_close, e_unc;
  fbe_pkg::kind_t                   byte_kind;
  logic [15:0]                      byte_off;
  fbe_pkg::status_t                 close_st;
  logic [7:0]                       close_id;
  logic [fbe_pkg::BODY_W-1:0]       unc_blen;
  logic [fbe_pkg::LANG_W-1:0]       lte_v;
  logic [fbe_pkg::BODY_W-1:0]       flb_v;
  logic [15:0]                      tl_v, of_v;
  fbe_pkg::res_t                    byte_res, close_res, unc_res, slot0, slot1;
  logic [1:0]                       n_res;

  assign in_stall  = (cnt_r > fbe_pkg::Q_CW'(fbe_pkg::Q_DEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + fbe_pkg::Q_AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r   <= fbe_pkg::MAX_BODY_RST;
      max_blocks_r <= fbe_pkg::MAX_BLOCKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbe_pkg::CFG_MAX_BODY:   max_body_r   <= cfg_wdata[15:0];
        fbe_pkg::CFG_MAX_BLOCKS: max_blocks_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    als_nxt      = als_r;
    tick_nxt     = tick_r;
    body_cnt_nxt = body_cnt_r;
    flb_nxt      = flb_r;
    bht_nxt      = bht_r;
    lht_nxt      = lht_r;
    lang_cnt_nxt = lang_cnt_r;
    lte_nxt      = lte_r;
    acc_cnt_nxt  = acc_cnt_r;
    tl_cnt_nxt   = tl_cnt_r;
    of_cnt_nxt   = of_cnt_r;
    e_byte       = 1'b0;
    e_close      = 1'b0;
    e_unc        = 1'b0;
    closed       = 1'b0;
    byte_kind    = fbe_pkg::KIND_BODY;
    byte_off     = '0;
    close_st     = fbe_pkg::ST_ACCEPTED;
    close_id     = '0;
    unc_blen     = '0;
    lte_v        = '0;
    flb_v        = '0;
    tl_v         = '0;
    of_v         = '0;
    if (in_acc) begin
      unique case (phase_r)
        fbe_pkg::PH_OUT: begin
          if (als_r) begin
            if (in_byte == fbe_pkg::CH_TICK) begin
              if (tick_r == 2'd2) begin
                phase_nxt    = fbe_pkg::PH_LANG;
                lang_cnt_nxt = '0;
                lte_nxt      = '0;
                tick_nxt     = '0;
              end else begin
                tick_nxt = tick_r + 2'd1;
              end
            end else if (in_byte == fbe_pkg::CH_LF) begin
              tick_nxt = '0;
            end else begin
              als_nxt  = 1'b0;
              tick_nxt = '0;
            end
          end else if (in_byte == fbe_pkg::CH_LF) begin
            als_nxt  = 1'b1;
            tick_nxt = '0;
          end
        end
        fbe_pkg::PH_LANG: begin
          byte_kind = fbe_pkg::KIND_LANG;
          byte_off  = 16'(lang_cnt_r);
          if (in_byte == fbe_pkg::CH_LF) begin
            phase_nxt    = fbe_pkg::PH_BODY;
            body_cnt_nxt = '0;
            flb_nxt      = '0;
            bht_nxt      = 1'b0;
            lht_nxt      = 1'b0;
            als_nxt      = 1'b1;
            tick_nxt     = '0;
          end else if (!fbe_pkg::is_blank(in_byte)) begin
            if (32'(lang_cnt_r) < fbe_pkg::MAX_LANG) begin
              e_byte       = 1'b1;
              lang_cnt_nxt = lang_cnt_r + fbe_pkg::LANG_W'(1);
              lte_nxt      = lang_cnt_r + fbe_pkg::LANG_W'(1);
            end else begin
              lte_nxt = fbe_pkg::LANG_W'(fbe_pkg::MAX_LANG);
            end
          end else if (lang_cnt_r != '0 && 32'(lang_cnt_r) < fbe_pkg::MAX_LANG) begin
            e_byte       = 1'b1;
            lang_cnt_nxt = lang_cnt_r + fbe_pkg::LANG_W'(1);
          end
        end
        fbe_pkg::PH_BODY: begin
          e_byte    = 1'b1;
          byte_kind = fbe_pkg::KIND_BODY;
          byte_off  = fbe_pkg::sat16(body_cnt_r);
          if (als_r) begin
            if (tick_r != 2'd3) begin
              if (in_byte == fbe_pkg::CH_TICK) begin
                tick_nxt = tick_r + 2'd1;
              end else begin
                als_nxt = 1'b0;
              end
            end else if (in_byte == fbe_pkg::CH_LF) begin
              closed = 1'b1;
            end else if (!fbe_pkg::is_blank(in_byte)) begin
              als_nxt = 1'b0;
            end
          end
          if (body_cnt_r != fbe_pkg::BODY_SAT) begin
            body_cnt_nxt = body_cnt_r + fbe_pkg::BODY_W'(1);
          end
          if (!closed) begin
            if (!fbe_pkg::is_blank(in_byte) && in_byte != fbe_pkg::CH_LF) begin
              lht_nxt = 1'b1;
            end
            if (in_byte == fbe_pkg::CH_LF) begin
              bht_nxt  = bht_r || lht_r;
              lht_nxt  = 1'b0;
              als_nxt  = 1'b1;
              tick_nxt = '0;
              flb_nxt  = body_cnt_nxt;
            end
            if (in_end_of_text && als_nxt && tick_nxt == 2'd3) begin
              closed = 1'b1;
            end
          end
          if (closed) begin
            e_close = 1'b1;
            if (!bht_nxt) begin
              close_st = fbe_pkg::ST_EMPTY;
            end else if (flb_nxt > {1'b0, max_body_r}) begin
              close_st = fbe_pkg::ST_TOO_LARGE;
              if (tl_cnt_r != 16'hFFFF) tl_cnt_nxt = tl_cnt_r + 16'd1;
            end else if (acc_cnt_r >= max_blocks_r) begin
              close_st = fbe_pkg::ST_OVERFLOW;
              if (of_cnt_r != 16'hFFFF) of_cnt_nxt = of_cnt_r + 16'd1;
            end else begin
              close_id = acc_cnt_r;
              if (acc_cnt_r != 8'hFF) acc_cnt_nxt = acc_cnt_r + 8'd1;
            end
            phase_nxt = fbe_pkg::PH_OUT;
            als_nxt   = 1'b1;
            tick_nxt  = '0;
          end
        end
        default: phase_nxt = fbe_pkg::PH_OUT;
      endcase
      lte_v    = lte_nxt;
      flb_v    = flb_nxt;
      tl_v     = tl_cnt_nxt;
      of_v     = of_cnt_nxt;
      unc_blen = (phase_nxt == fbe_pkg::PH_BODY) ? body_cnt_nxt : '0;
      if (in_end_of_text) begin
        e_unc        = (phase_nxt != fbe_pkg::PH_OUT);
        phase_nxt    = fbe_pkg::PH_OUT;
        als_nxt      = 1'b1;
        tick_nxt     = '0;
        body_cnt_nxt = '0;
        flb_nxt      = '0;
        bht_nxt      = 1'b0;
        lht_nxt      = 1'b0;
        lang_cnt_nxt = '0;
        lte_nxt      = '0;
        acc_cnt_nxt  = '0;
        tl_cnt_nxt   = '0;
        of_cnt_nxt   = '0;
      end
    end
  end

  always_comb begin
    byte_res             = '0;
    byte_res.kind        = byte_kind;
    byte_res.out_byte    = in_byte;
    byte_res.offset      = byte_off;

    close_res                 = '0;
    close_res.kind            = fbe_pkg::KIND_VERDICT;
    close_res.blk_num         = close_id;
    close_res.status          = close_st;
    close_res.body_length     = fbe_pkg::sat16(flb_v);
    close_res.lang_length     = fbe_pkg::lang_out(lte_v);
    close_res.too_large_total = tl_v;
    close_res.overflow_total  = of_v;

    unc_res                 = '0;
    unc_res.kind            = fbe_pkg::KIND_VERDICT;
    unc_res.status          = fbe_pkg::ST_UNCLOSED;
    unc_res.body_length     = fbe_pkg::sat16(unc_blen);
    unc_res.lang_length     = fbe_pkg::lang_out(lte_v);
    unc_res.too_large_total = tl_v;
    unc_res.overflow_total  = of_v;

    n_res = 2'(e_byte) + 2'(e_close) + 2'(e_unc);
    slot0 = e_byte ? byte_res : (e_close ? close_res : unc_res);
    slot1 = e_byte ? (e_close ? close_res : unc_res) : unc_res;
    slot0.last_result = (n_res == 2'd1);
    slot1.last_result = 1'b1;
  end

  always_comb begin
    cnt_nxt = cnt_r + fbe_pkg::Q_CW'(n_res) - fbe_pkg::Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) q_r[wr_ptr_r] <= slot0;
    if (n_res == 2'd2) q_r[wr_ptr_p1] <= slot1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= fbe_pkg::PH_OUT;
      als_r      <= 1'b1;
      tick_r     <= '0;
      body_cnt_r <= '0;
      flb_r      <= '0;
      bht_r      <= 1'b0;
      lht_r      <= 1'b0;
      lang_cnt_r <= '0;
      lte_r      <= '0;
      acc_cnt_r  <= '0;
      tl_cnt_r   <= '0;
      of_cnt_r   <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      als_r      <= als_nxt;
      tick_r     <= tick_nxt;
      body_cnt_r <= body_cnt_nxt;
      flb_r      <= flb_nxt;
      bht_r      <= bht_nxt;
      lht_r      <= lht_nxt;
      lang_cnt_r <= lang_cnt_nxt;
      lte_r      <= lte_nxt;
      acc_cnt_r  <= acc_cnt_nxt;
      tl_cnt_r   <= tl_cnt_nxt;
      of_cnt_r   <= of_cnt_nxt;
      wr_ptr_r   <= wr_ptr_r + fbe_pkg::Q_AW'(n_res);
      rd_ptr_r   <= rd_ptr_r + fbe_pkg::Q_AW'(pop);
      cnt_r      <= cnt_nxt;
    end
  end

  assign out_kind            = q_r[rd_ptr_r].kind;
  assign out_byte            = q_r[rd_ptr_r].out_byte;
  assign out_offset          = q_r[rd_ptr_r].offset;
  assign out_blk_num         = q_r[rd_ptr_r].blk_num;
  assign out_status          = q_r[rd_ptr_r].status;
  assign out_body_length     = q_r[rd_ptr_r].body_length;
  assign out_lang_length     = q_r[rd_ptr_r].lang_length;
  assign out_too_large_total = q_r[rd_ptr_r].too_large_total;
  assign out_overflow_total  = q_r[rd_ptr_r].overflow_total;
  assign out_last_result     = q_r[rd_ptr_r].last_result;

endmodule

FILE: sim/fenced_block_extractor_tb.sv
// ----------------------------------------------------------------------------
// fenced_block_extractor_tb: self-checking bench for the fenced block extractor
// Feeds directed and random texts (well-formed fenced blocks, broken blocks
// and noise) under random input gaps and output stalls, across several
// register settings. A behavioral scan of each text predicts every language
// byte, body byte and verdict, and each output beat is compared against it.
// ----------------------------------------------------------------------------
module fenced_block_extractor_tb;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_byte        = '0;
  logic                           in_end_of_text = 1'b0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic [1:0]                     out_kind;
  logic [7:0]                     out_byte;
  logic [15:0]                    out_offset;
  logic [7:0]                     out_blk_num;
  logic [2:0]                     out_status;
  logic [15:0]                    out_body_length;
  logic [6:0]                     out_lang_length;
  logic [15:0]                    out_too_large_total;
  logic [15:0]                    out_overflow_total;
  logic                           out_last_result;
  logic                           cfg_we         = 1'b0;
  logic [fbe_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [fbe_pkg::CFG_DATA_W-1:0] cfg_wdata      = '0;

  // scanner state of the prediction
  fbe_pkg::phase_t scan_phase;
  logic            at_sol;
  logic [1:0]      ticks;
  logic [16:0]     body_len;
  logic [16:0]     fence_begin;
  logic            block_has_text;
  logic            cur_line_text;
  logic [6:0]      lang_len;
  logic [6:0]      lang_keep;
  logic [7:0]      blocks_taken;
  logic [15:0]     drops_large;
  logic [15:0]     drops_over;
  logic [15:0]     lim_body;
  logic [7:0]      lim_blocks;

  fbe_pkg::res_t predicted_results[$];
  logic [7:0]    text_bytes[$];
  int            fail_count   = 0;
  int            bytes_sent   = 0;
  int            quiet_cycles = 0;
  bit            idle_on      = 1'b1;
  bit            sender_idle  = 1'b1;
  bit            hold_req     = 1'b0;

  fenced_block_extractor u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte             (in_byte),
    .in_end_of_text      (in_end_of_text),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_byte            (out_byte),
    .out_offset          (out_offset),
    .out_blk_num         (out_blk_num),
    .out_status          (out_status),
    .out_body_length     (out_body_length),
    .out_lang_length     (out_lang_length),
    .out_too_large_total (out_too_large_total),
    .out_overflow_total  (out_overflow_total),
    .out_last_result     (out_last_result),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic logic blank_byte(input logic [7:0] c);
    return c == fbe_pkg::CH_SP || c == fbe_pkg::CH_TAB || c == fbe_pkg::CH_CR;
  endfunction

  function automatic logic [15:0] clip16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void clear_scan();
    scan_phase     = fbe_pkg::PH_OUT;
    at_sol         = 1'b1;
    ticks          = '0;
    body_len       = '0;
    fence_begin    = '0;
    block_has_text = 1'b0;
    cur_line_text  = 1'b0;
    lang_len       = '0;
    lang_keep      = '0;
    blocks_taken   = '0;
    drops_large    = '0;
    drops_over     = '0;
  endfunction

  function automatic fbe_pkg::res_t make_result(input fbe_pkg::kind_t k,
                                                input logic [7:0] b,
                                                input logic [16:0] off,
                                                input fbe_pkg::status_t st,
                                                input logic [7:0] id,
                                                input logic [16:0] blen);
    fbe_pkg::res_t r;
    r = '0;
    r.kind     = k;
    r.out_byte = b;
    r.offset   = clip16(off);
    r.blk_num  = id;
    r.status   = st;
    if (k == fbe_pkg::KIND_VERDICT) begin
      r.body_length     = clip16(blen);
      r.lang_length     = lang_keep;
      r.too_large_total = drops_large;
      r.overflow_total  = drops_over;
    end
    return r;
  endfunction

  function automatic void extract_byte(input logic [7:0] b, input logic eot);
    fbe_pkg::res_t    beats[$];
    logic             closed;
    fbe_pkg::status_t st;
    logic [7:0]       id;
    closed = 1'b0;
    case (scan_phase)
      fbe_pkg::PH_OUT: begin
        if (at_sol) begin
          if (b == fbe_pkg::CH_TICK) begin
            ticks = ticks + 2'd1;
            if (ticks == 2'd3) begin
              scan_phase = fbe_pkg::PH_LANG;
              lang_len   = '0;
              lang_keep  = '0;
              ticks      = '0;
            end
          end else if (b == fbe_pkg::CH_LF) begin
            ticks = '0;
          end else begin
            at_sol = 1'b0;
            ticks  = '0;
          end
        end else if (b == fbe_pkg::CH_LF) begin
          at_sol = 1'b1;
          ticks  = '0;
        end
      end
      fbe_pkg::PH_LANG: begin
        if (b == fbe_pkg::CH_LF) begin
          scan_phase     = fbe_pkg::PH_BODY;
          body_len       = '0;
          fence_begin    = '0;
          block_has_text = 1'b0;
          cur_line_text  = 1'b0;
          at_sol         = 1'b1;
          ticks          = '0;
        end else if (!blank_byte(b)) begin
          if (lang_len < fbe_pkg::MAX_LANG) begin
            beats = {beats, make_result(fbe_pkg::KIND_LANG, b, 17'(lang_len),
                                        fbe_pkg::ST_ACCEPTED, 8'd0, 17'd0)};
            lang_len  = lang_len + 7'd1;
            lang_keep = lang_len;
          end else begin
            lang_keep = 7'(fbe_pkg::MAX_LANG);
          end
        end else if (lang_len > 0 && lang_len < fbe_pkg::MAX_LANG) begin
          beats = {beats, make_result(fbe_pkg::KIND_LANG, b, 17'(lang_len),
                                      fbe_pkg::ST_ACCEPTED, 8'd0, 17'd0)};
          lang_len = lang_len + 7'd1;
        end
      end
      default: begin
        beats = {beats, make_result(fbe_pkg::KIND_BODY, b, body_len,
                                    fbe_pkg::ST_ACCEPTED, 8'd0, 17'd0)};
        if (at_sol) begin
          if (ticks < 2'd3) begin
            if (b == fbe_pkg::CH_TICK) ticks = ticks + 2'd1;
            else at_sol = 1'b0;
          end else if (b == fbe_pkg::CH_LF) begin
            closed = 1'b1;
          end else if (!blank_byte(b)) begin
            at_sol = 1'b0;
          end
        end
        if (body_len != fbe_pkg::BODY_SAT) body_len = body_len + 17'd1;
        if (!closed) begin
          if (!blank_byte(b) && b != fbe_pkg::CH_LF) cur_line_text = 1'b1;
          if (b == fbe_pkg::CH_LF) begin
            block_has_text = block_has_text | cur_line_text;
            cur_line_text  = 1'b0;
            at_sol         = 1'b1;
            ticks          = '0;
            fence_begin    = body_len;
          end
          if (eot && at_sol && ticks == 2'd3) closed = 1'b1;
        end
        if (closed) begin
          id = 8'd0;
          if (!block_has_text) begin
            st = fbe_pkg::ST_EMPTY;
          end else if (fence_begin > 17'(lim_body)) begin
            st = fbe_pkg::ST_TOO_LARGE;
            if (drops_large != 16'hFFFF) drops_large = drops_large + 16'd1;
          end else if (blocks_taken >= lim_blocks) begin
            st = fbe_pkg::ST_OVERFLOW;
            if (drops_over != 16'hFFFF) drops_over = drops_over + 16'd1;
          end else begin
            st = fbe_pkg::ST_ACCEPTED;
            id = blocks_taken;
            if (blocks_taken != 8'hFF) blocks_taken = blocks_taken + 8'd1;
          end
          beats = {beats, make_result(fbe_pkg::KIND_VERDICT, 8'd0, 17'd0, st, id,
                                      fence_begin)};
          scan_phase = fbe_pkg::PH_OUT;
          at_sol     = 1'b1;
          ticks      = '0;
        end
      end
    endcase
    if (eot) begin
      if (scan_phase != fbe_pkg::PH_OUT)
        beats = {beats, make_result(fbe_pkg::KIND_VERDICT, 8'd0, 17'd0,
                                    fbe_pkg::ST_UNCLOSED, 8'd0,
                                    scan_phase == fbe_pkg::PH_BODY ? body_len : 17'd0)};
      clear_scan();
    end
    if (beats.size() > 0) begin
      beats[beats.size() - 1].last_result = 1'b1;
      predicted_results = {predicted_results, beats};
    end
  endfunction

  // ------------------------------------------------------------------ checking

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    fbe_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat: expected none, actual kind %0d byte %0d status %0d",
                 $time, out_kind, out_byte, out_status);
      end else begin
        want = predicted_results.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("byte", want.out_byte, out_byte);
        check_field("offset", want.offset, out_offset);
        check_field("blk_num", want.blk_num, out_blk_num);
        check_field("status", want.status, out_status);
        check_field("body_length", want.body_length, out_body_length);
        check_field("lang_length", want.lang_length, out_lang_length);
        check_field("too_large_total", want.too_large_total, out_too_large_total);
        check_field("overflow_total", want.overflow_total, out_overflow_total);
        check_field("last_result", want.last_result, out_last_result);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold on request
  initial begin : result_side
    int burst;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    extract_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic send_text();
    sender_idle = idle_on && ($urandom_range(0, 3) != 0);
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fbe_pkg::CFG_MAX_BODY) lim_body = data;
    else if (idx == fbe_pkg::CFG_MAX_BLOCKS) lim_blocks = data[7:0];
  endtask

  task automatic set_limits(input logic [15:0] body, input logic [7:0] blocks);
    drain();
    write_reg(fbe_pkg::CFG_MAX_BODY, body);
    write_reg(fbe_pkg::CFG_MAX_BLOCKS, 16'(blocks));
  endtask

  // ------------------------------------------------------------- text building

  function automatic void add_char(input logic [7:0] c);
    text_bytes = {text_bytes, c};
  endfunction

  function automatic logic [7:0] blank_pick();
    case ($urandom_range(0, 2))
      0: return fbe_pkg::CH_SP;
      1: return fbe_pkg::CH_TAB;
      default: return fbe_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] line_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1: c = fbe_pkg::CH_SP;
      2: c = fbe_pkg::CH_TAB;
      3: c = fbe_pkg::CH_CR;
      4: c = fbe_pkg::CH_TICK;
      5: c = 8'($urandom_range(0, 255));
      default: c = 8'($urandom_range(8'h61, 8'h7A));
    endcase
    if (c == fbe_pkg::CH_LF) c = 8'h80;
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 5))
      0, 1: return fbe_pkg::CH_TICK;
      2: return fbe_pkg::CH_LF;
      default: return line_char();
    endcase
  endfunction

  function automatic void push_ticks(input int n);
    repeat (n) add_char(fbe_pkg::CH_TICK);
  endfunction

  function automatic void add_prose_line();
    case ($urandom_range(0, 5))
      0: push_ticks($urandom_range(1, 2));
      1: ;
      2: begin
        add_char(blank_pick());
        push_ticks(3);
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 10)) add_char(line_char());
    add_char(fbe_pkg::CH_LF);
  endfunction

  function automatic void add_opener(input bit with_lf);
    int n;
    push_ticks(3);
    repeat ($urandom_range(0, 2)) add_char(blank_pick());
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = $urandom_range(60, 80);
      default: n = $urandom_range(1, 6);
    endcase
    repeat (n) add_char(line_char());
    repeat ($urandom_range(0, 2)) add_char(blank_pick());
    if (with_lf) add_char(fbe_pkg::CH_LF);
  endfunction

  function automatic void add_body_line();
    case ($urandom_range(0, 7))
      0: repeat ($urandom_range(0, 3)) add_char(blank_pick());
      1: begin
        push_ticks($urandom_range(1, 4));
        repeat ($urandom_range(0, 3)) add_char(line_char());
      end
      default: repeat ($urandom_range(1, 10)) add_char(line_char());
    endcase
    add_char(fbe_pkg::CH_LF);
  endfunction

  function automatic void add_closer(input bit with_lf);
    push_ticks(3);
    repeat ($urandom_range(0, 2)) add_char(blank_pick());
    if (with_lf) add_char(fbe_pkg::CH_LF);
  endfunction

  // mostly well-formed texts: prose, then blocks with optional prose after each; the tail block may be cut short
  function automatic void build_text();
    int blocks;
    int ending;
    bit tail;
    text_bytes.delete();
    blocks = $urandom_range(0, 4);
    ending = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) add_prose_line();
    for (int i = 0; i < blocks; i++) begin
      tail = (i == blocks - 1);
      if (tail && ending == 0) begin
        add_opener(1'b0);
      end else begin
        add_opener(1'b1);
        repeat ($urandom_range(0, 5)) add_body_line();
        if (!(tail && ending == 1)) add_closer(!(tail && ending == 2));
        if (!tail || ending > 2) repeat ($urandom_range(0, 1)) add_prose_line();
      end
    end
    if (text_bytes.size() == 0) add_char(line_char());
  endfunction

  task automatic send_random_text();
    if ($urandom_range(0, 4) == 0) begin
      text_bytes.delete();
      repeat ($urandom_range(1, 30)) add_char(noise_char());
    end else begin
      build_text();
    end
    send_text();
  endtask

  // --------------------------------------------------------------------- tests

  task automatic test_directed();
    text_bytes = {fbe_pkg::CH_TICK, fbe_pkg::CH_TICK, fbe_pkg::CH_TICK, fbe_pkg::CH_SP,
                  8'h61, fbe_pkg::CH_SP, fbe_pkg::CH_LF,
                  8'hFF, 8'h00, fbe_pkg::CH_LF,
                  fbe_pkg::CH_TICK, fbe_pkg::CH_TICK, fbe_pkg::CH_TICK, fbe_pkg::CH_SP,
                  fbe_pkg::CH_CR, fbe_pkg::CH_LF,
                  fbe_pkg::CH_TICK, fbe_pkg::CH_TICK, fbe_pkg::CH_TICK, fbe_pkg::CH_LF,
                  fbe_pkg::CH_TAB, fbe_pkg::CH_LF,
                  fbe_pkg::CH_TICK, fbe_pkg::CH_TICK, fbe_pkg::CH_TICK};
    send_text();
  endtask

  task automatic test_register_sweep();
    logic [15:0] bodies[5];
    logic [7:0]  counts[5];
    int          stop_at;
    bodies = '{16'd0, 16'hFFFF, 16'd1, 16'd5, fbe_pkg::MAX_BODY_RST};
    counts = '{8'd0, 8'hFF, 8'd1, 8'd2, fbe_pkg::MAX_BLOCKS_RST};
    for (int k = 0; k < 5; k++) begin
      set_limits(bodies[k], counts[k]);
      stop_at = bytes_sent + 100;
      while (bytes_sent < stop_at) send_random_text();
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;
    text_bytes.delete();
    add_opener(1'b1);
    repeat (8) add_body_line();
    add_closer(1'b1);
    send_text();
    while (hold_req) @(posedge clk);
  endtask

  task automatic test_random_texts();
    int stop_at;
    for (int round = 0; round < 4; round++) begin
      set_limits(16'($urandom_range(8, 64)), 8'($urandom_range(1, 4)));
      if (round == 3) idle_on = 1'b0;
      stop_at = bytes_sent + 200;
      while (bytes_sent < stop_at) send_random_text();
    end
  endtask

  initial begin
    clear_scan();
    lim_body   = fbe_pkg::MAX_BODY_RST;
    lim_blocks = fbe_pkg::MAX_BLOCKS_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_sweep();
    test_backpressure();
    test_random_texts();
    drain();
    if (fail_count == 0 && predicted_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: fenced_block_extractor.f
rtl/fbe_pkg.sv
rtl/fenced_block_extractor.sv
sim/fenced_block_extractor_tb.sv
